@@ hw/rtl/windowed_peak_rms_crest_meter_macros.svh @@
// Assertion helpers
`ifndef WINDOWED_PEAK_RMS_CREST_METER_MACROS_SVH
`define WINDOWED_PEAK_RMS_CREST_METER_MACROS_SVH
`define WPRC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define WPRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ hw/rtl/wprc_pkg.sv @@
package wprc_pkg;
  localparam int SAMPLE_BITS = 24;
  localparam int MAG_BITS = SAMPLE_BITS;
  localparam int SQUARE_DROP = 4;
  localparam int SQ_BITS = 2 * SAMPLE_BITS - SQUARE_DROP;
  localparam int CNT_BITS = 22;
  localparam int WIN_BITS = 19;
  localparam logic [WIN_BITS-1:0] WIN_RESET = 19'd48000;
  localparam logic [WIN_BITS-1:0] MAX_WINDOW = 19'd262144;
  localparam logic [CNT_BITS-1:0] CNT_MAX = 22'h3FFFFF;
  localparam logic [63:0] DB_PER_LOG2_Q16 = 64'd50504453;
  localparam logic [38:0] LOG_MAG_CAP = 39'h5000000000;
  localparam int DB_FLOOR_MAG = 35584;

  typedef struct packed {
    logic [MAG_BITS-1:0] peak;
    logic [63:0] sum;
    logic [CNT_BITS-1:0] count;
  } window_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOGA, S_LOGB, S_LOGC, S_DIFF, S_MUL, S_NEXT, S_OUT
  } back_state_t;
endpackage

@@ hw/rtl/windowed_peak_rms_crest_meter.sv @@
// Windowed peak / RMS / crest meter.
// Input queue side: push with sample and frame_end; accepted when push && !full.
// Each sample passes the accumulate stage (one register for the square,
// one for the sums); a new sample is not accepted until the last is summed.
// After window_frames frame_end items a window record passes to the
// back end, which computes two pairs of fixed-point log2 values (32 squaring
// steps each, one per cycle) and scales them to dB in Q8.8.
// Results appear on peak_dbfs, rms_dbfs, crest_db while empty is low;
// pop takes one. A silent window gives no result.
// If the result is not popped, one further window record can wait between
// the front and back; after that full stays high.
// Configuration: cfg_valid/cfg_ready write window_frames and clear the sums.
// Reset (rst, synchronous) sets window_frames to 48000, clears sums and flags.
module windowed_peak_rms_crest_meter (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic signed [23:0] sample,
  input  logic frame_end,
  output logic empty,
  input  logic pop,
  output logic signed [16:0] peak_dbfs,
  output logic signed [16:0] rms_dbfs,
  output logic [15:0] crest_db,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [18:0] cfg_data
);
  logic win_valid, win_ready;
  wprc_pkg::window_t win;

  assign cfg_ready = 1'b1;

  wprc_front u_front (
    .clk, .rst, .push, .full, .sample, .frame_end,
    .cfg_valid, .cfg_data, .win_valid, .win, .win_ready
  );

  wprc_back u_back (
    .clk, .rst, .win_valid, .win, .win_ready, .empty, .pop,
    .peak_dbfs, .rms_dbfs, .crest_db
  );
endmodule

@@ hw/rtl/wprc_front.sv @@
module wprc_front (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic signed [wprc_pkg::SAMPLE_BITS-1:0] sample,
  input  logic frame_end,
  input  logic cfg_valid,
  input  logic [wprc_pkg::WIN_BITS-1:0] cfg_data,
  output logic win_valid,
  output wprc_pkg::window_t win,
  input  logic win_ready
);
  logic [wprc_pkg::WIN_BITS-1:0] window_frames;
  logic [wprc_pkg::MAG_BITS-1:0] peak_magnitude;
  logic [63:0] square_sum;
  logic [wprc_pkg::CNT_BITS-1:0] sample_count;
  logic [wprc_pkg::WIN_BITS-1:0] frame_count;
  logic [wprc_pkg::MAG_BITS-1:0] mag;
  logic [wprc_pkg::SQ_BITS-1:0] sq;
  logic [64:0] sum_ext;
  logic [wprc_pkg::WIN_BITS-1:0] win_lim;
  logic [wprc_pkg::MAG_BITS-1:0] pk_n;
  logic [63:0] sum_n;
  logic [wprc_pkg::CNT_BITS-1:0] cnt_n;
  logic [wprc_pkg::WIN_BITS-1:0] fc_n;
  logic fire, accept;
  logic sq_valid;
  logic [wprc_pkg::SQ_BITS-1:0] sq_r;
  logic [wprc_pkg::MAG_BITS-1:0] mag_r;
  logic fe_r;

  assign full = win_valid || sq_valid;
  assign accept = push && !full;
  assign mag = sample[wprc_pkg::SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
  assign sq = wprc_pkg::SQ_BITS'((48'(mag) * 48'(mag)) >> wprc_pkg::SQUARE_DROP);

  always_comb begin
    win_lim = window_frames;
    if (win_lim == '0) win_lim = 19'd1;
    if (win_lim > wprc_pkg::MAX_WINDOW) win_lim = wprc_pkg::MAX_WINDOW;
    pk_n = (mag_r > peak_magnitude) ? mag_r : peak_magnitude;
    sum_ext = {1'b0, square_sum} + 65'(sq_r);
    sum_n = sum_ext[64] ? '1 : sum_ext[63:0];
    cnt_n = (sample_count < wprc_pkg::CNT_MAX) ? sample_count + 1'b1 : sample_count;
    fc_n = frame_count + 1'b1;
    fire = fe_r && (fc_n >= win_lim);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_frames <= wprc_pkg::WIN_RESET;
      peak_magnitude <= '0;
      square_sum <= '0;
      sample_count <= '0;
      frame_count <= '0;
      sq_valid <= 1'b0;
      win_valid <= 1'b0;
    end else begin
      if (win_valid && win_ready) win_valid <= 1'b0;
      if (accept) begin
        sq_valid <= 1'b1;
        sq_r <= sq;
        mag_r <= mag;
        fe_r <= frame_end;
      end
      if (sq_valid) begin
        sq_valid <= 1'b0;
        if (fire) begin
          peak_magnitude <= '0;
          square_sum <= '0;
          sample_count <= '0;
          frame_count <= '0;
          if (pk_n != '0 && sum_n != '0) begin
            win_valid <= 1'b1;
            win <= '{peak: pk_n, sum: sum_n, count: cnt_n};
          end
        end else begin
          peak_magnitude <= pk_n;
          square_sum <= sum_n;
          sample_count <= cnt_n;
          if (fe_r) frame_count <= fc_n;
        end
      end
      if (cfg_valid) begin
        window_frames <= cfg_data;
        peak_magnitude <= '0;
        square_sum <= '0;
        sample_count <= '0;
        frame_count <= '0;
      end
    end
  end
endmodule

@@ hw/rtl/wprc_back.sv @@
`include "windowed_peak_rms_crest_meter_macros.svh"
module wprc_back (
  input  logic clk,
  input  logic rst,
  input  logic win_valid,
  input  wprc_pkg::window_t win,
  output logic win_ready,
  output logic empty,
  input  logic pop,
  output logic signed [16:0] peak_dbfs,
  output logic signed [16:0] rms_dbfs,
  output logic [15:0] crest_db
);
  wprc_pkg::back_state_t state, state_next;
  wprc_pkg::window_t job;
  logic pass;
  logic [63:0] arg_a, arg_b;
  logic [5:0] ea, eb;
  logic [32:0] m;
  logic [31:0] fa, fb;
  logic [5:0] it;
  logic which;
  logic [38:0] lmag;
  logic neg;
  logic [101:0] prod;
  logic signed [16:0] pk, v;
  logic [5:0] top;
  logic [63:0] norm;
  logic [65:0] sqm;
  logic [32:0] msq;
  logic signed [40:0] lsum;
  logic signed [17:0] cr;

  assign win_ready = (state == wprc_pkg::S_IDLE) && empty;

  always_comb begin
    top = '0;
    for (int i = 1; i < 64; i++) if ((which ? arg_b[i] : arg_a[i])) top = 6'(i);
    norm = (which ? arg_b : arg_a) << (6'd63 - top);
    sqm = 66'(m) * 66'(m);
    msq = 33'(sqm >> 31);
    lsum = 41'($signed({2'b0, ea, fa})) - 41'($signed({2'b0, eb, fb}))
         + (pass ? -41'sd42 <<< 32 : -41'sd46 <<< 32);
    v = neg ? -17'sd0 - $signed({1'b0, prod[63:48]}) : $signed({1'b0, prod[63:48]});
    if (v < -17'sd35584) v = -17'sd35584;
    if (v > 17'sd0) v = 17'sd0;
    cr = 18'(pk) - 18'(v);
    if (cr < 0) cr = 0;
    if (cr > 18'sd35584) cr = 18'sd35584;
    state_next = state;
    case (state)
      wprc_pkg::S_IDLE: if (win_valid && empty) state_next = wprc_pkg::S_LOGA;
      wprc_pkg::S_LOGA: state_next = wprc_pkg::S_LOGB;
      wprc_pkg::S_LOGB: if (it == 6'd0) state_next = wprc_pkg::S_LOGC;
      wprc_pkg::S_LOGC: state_next = which ? wprc_pkg::S_DIFF : wprc_pkg::S_LOGA;
      wprc_pkg::S_DIFF: state_next = wprc_pkg::S_MUL;
      wprc_pkg::S_MUL: state_next = wprc_pkg::S_NEXT;
      wprc_pkg::S_NEXT: state_next = pass ? wprc_pkg::S_OUT : wprc_pkg::S_LOGA;
      wprc_pkg::S_OUT: state_next = wprc_pkg::S_IDLE;
      default: state_next = wprc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wprc_pkg::S_IDLE;
      empty <= 1'b1;
    end else begin
      state <= state_next;
      if (!empty && pop) empty <= 1'b1;
      case (state)
        wprc_pkg::S_IDLE: if (win_valid && empty) begin
          job <= win;
          pass <= 1'b0;
          which <= 1'b0;
          arg_a <= 64'(win.peak) * 64'(win.peak);
          arg_b <= 64'd1;
        end
        wprc_pkg::S_LOGA: begin
          if (which) eb <= top; else ea <= top;
          m <= {1'b0, norm[63:32]};
          it <= 6'd31;
          if (which) fb <= '0; else fa <= '0;
        end
        wprc_pkg::S_LOGB: begin
          if (msq[32]) begin
            m <= {1'b0, msq[32:1]};
            if (which) fb[it[4:0]] <= 1'b1; else fa[it[4:0]] <= 1'b1;
          end else m <= msq;
          it <= it - 1'b1;
        end
        wprc_pkg::S_LOGC: which <= ~which;
        wprc_pkg::S_DIFF: begin
          neg <= lsum < 0;
          lmag <= (lsum < 0) ? 39'(-lsum) : 39'(lsum);
        end
        wprc_pkg::S_MUL: begin
          prod <= 102'(((lmag > wprc_pkg::LOG_MAG_CAP) ? wprc_pkg::LOG_MAG_CAP : lmag))
                  * 102'(wprc_pkg::DB_PER_LOG2_Q16) + (102'd1 << 47);
        end
        wprc_pkg::S_NEXT: begin
          if (!pass) begin
            pk <= v;
            pass <= 1'b1;
            which <= 1'b0;
            arg_a <= job.sum;
            arg_b <= 64'(job.count);
          end else begin
            rms_dbfs <= v;
            peak_dbfs <= pk;
            crest_db <= 16'(cr);
          end
        end
        wprc_pkg::S_OUT: empty <= 1'b0;
        default: ;
      endcase
    end
  end

  `WPRC_ASSERT_IMPL(a_ready_idle, clk, rst, win_ready, state == wprc_pkg::S_IDLE)
  `WPRC_ASSERT_NEXT(a_out_sets, clk, rst, state == wprc_pkg::S_OUT, !empty)
  `WPRC_ASSERT_IMPL(a_hold, clk, rst, !empty, state == wprc_pkg::S_IDLE)
endmodule
